// ----- hdl/sgsrl_pkg.sv -----
// Shared types and constants of the steering gain scheduler with rate limiting.
`default_nettype none

package sgsrl_pkg;

  // Field and port widths
  localparam int VAL_W     = 16;
  localparam int SET_W     = 64;
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;
  localparam int REG_IDX_W = 3;

  // Register indexes, one 64-bit slot each (byte address 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_LOW_THR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STRAIGHT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CURVE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RISE_RATE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FALL_RATE = 3'd5;

  // Register reset values
  localparam logic [VAL_W-1:0] LOW_THR_RST  = 16'd819;
  localparam logic [VAL_W-1:0] HIGH_THR_RST = 16'd2048;
  localparam logic [SET_W-1:0] STRAIGHT_RST = 64'h0320_0002_001E_0055;
  localparam logic [SET_W-1:0] CURVE_RST    = 64'h012C_0002_000A_0055;
  localparam logic [SET_W-1:0] RISE_RST     = 64'h1388_0032_0064_01F4;
  localparam logic [SET_W-1:0] FALL_RST     = 64'hFA24_FFCE_FF9C_FE0C;

  // Arithmetic widths: scale = 1000 * D, dtd = dt * D, wide terms on 1 / (1000 * D)
  localparam int MS_PER_S = 1000;
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 27;
  localparam int WIDE_W   = 50;
  localparam int SCALE_W  = 26;
  localparam int DTD_W    = 32;
  localparam int ACC_W    = 33;
  localparam int Q_W      = 17;
  localparam int BIT_W    = 5;
  localparam logic [BIT_W-1:0] DIV_LAST = 5'd16;

  typedef struct packed {
    logic [VAL_W-1:0] low_thr;
    logic [VAL_W-1:0] high_thr;
    logic [SET_W-1:0] straight_set;
    logic [SET_W-1:0] curve_set;
    logic [SET_W-1:0] rise_rate;
    logic [SET_W-1:0] fall_rate;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_CURVE,
    MODE_STRAIGHT,
    MODE_BLEND
  } mode_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SET_CURVE,
    OP_SET_STRAIGHT,
    OP_MUL_SCALE,
    OP_MUL_DTD,
    OP_MUL_STR,
    OP_MAC_CRV,
    OP_MUL_TGT,
    OP_MUL_CUR,
    OP_MUL_UP,
    OP_MUL_DN,
    OP_CLAMP_A,
    OP_CLAMP_B,
    OP_CLAMP_C,
    OP_DIV_STEP,
    OP_WRITE,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [LANE_W-1:0] lane;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/sgsrl_if.sv -----
// Valid/ready channel interfaces for steering reports and parameter results.
`default_nettype none

interface sgsrl_in_if;
  logic                         valid;
  logic                         ready;
  logic [sgsrl_pkg::VAL_W-1:0]  steer_command_abs;
  logic [sgsrl_pkg::VAL_W-1:0]  steer_output_abs;
  logic                         enabled;
  logic [sgsrl_pkg::VAL_W-1:0]  elapsed_ms;

  modport source (output valid, steer_command_abs, steer_output_abs, enabled, elapsed_ms,
                  input ready);
  modport sink   (input valid, steer_command_abs, steer_output_abs, enabled, elapsed_ms,
                  output ready);
endinterface

interface sgsrl_out_if;
  logic                         valid;
  logic                         ready;
  logic [sgsrl_pkg::VAL_W-1:0]  prop_gain;
  logic [sgsrl_pkg::VAL_W-1:0]  integ_gain;
  logic [sgsrl_pkg::VAL_W-1:0]  friction_coeff;
  logic [sgsrl_pkg::VAL_W-1:0]  return_offset;
  logic [sgsrl_pkg::SET_W-1:0]  frame_payload;

  modport source (output valid, prop_gain, integ_gain, friction_coeff, return_offset,
                  frame_payload, input ready);
  modport sink   (input valid, prop_gain, integ_gain, friction_coeff, return_offset,
                  frame_payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/sgsrl_regs.sv -----
// APB configuration register file: thresholds, parameter sets and rate limits.
`default_nettype none

module sgsrl_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sgsrl_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sgsrl_pkg::PDATA_W-1:0] pwdata,
  output logic      [sgsrl_pkg::PDATA_W-1:0] prdata,
  output logic                               pready,
  output sgsrl_pkg::cfg_t                    cfg
);

  logic [sgsrl_pkg::REG_IDX_W-1:0] idx;
  logic                            wr_en;
  sgsrl_pkg::cfg_t                 cfg_r;

  assign idx    = paddr[sgsrl_pkg::PADDR_W-1:sgsrl_pkg::PADDR_W-sgsrl_pkg::REG_IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write on the access cycle of a transfer; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr      <= sgsrl_pkg::LOW_THR_RST;
      cfg_r.high_thr     <= sgsrl_pkg::HIGH_THR_RST;
      cfg_r.straight_set <= sgsrl_pkg::STRAIGHT_RST;
      cfg_r.curve_set    <= sgsrl_pkg::CURVE_RST;
      cfg_r.rise_rate    <= sgsrl_pkg::RISE_RST;
      cfg_r.fall_rate    <= sgsrl_pkg::FALL_RST;
    end else if (wr_en) begin
      case (idx)
        sgsrl_pkg::REG_LOW_THR:   cfg_r.low_thr      <= pwdata[sgsrl_pkg::VAL_W-1:0];
        sgsrl_pkg::REG_HIGH_THR:  cfg_r.high_thr     <= pwdata[sgsrl_pkg::VAL_W-1:0];
        sgsrl_pkg::REG_STRAIGHT:  cfg_r.straight_set <= pwdata;
        sgsrl_pkg::REG_CURVE:     cfg_r.curve_set    <= pwdata;
        sgsrl_pkg::REG_RISE_RATE: cfg_r.rise_rate    <= pwdata;
        sgsrl_pkg::REG_FALL_RATE: cfg_r.fall_rate    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      sgsrl_pkg::REG_LOW_THR:   prdata = sgsrl_pkg::PDATA_W'(cfg_r.low_thr);
      sgsrl_pkg::REG_HIGH_THR:  prdata = sgsrl_pkg::PDATA_W'(cfg_r.high_thr);
      sgsrl_pkg::REG_STRAIGHT:  prdata = cfg_r.straight_set;
      sgsrl_pkg::REG_CURVE:     prdata = cfg_r.curve_set;
      sgsrl_pkg::REG_RISE_RATE: prdata = cfg_r.rise_rate;
      sgsrl_pkg::REG_FALL_RATE: prdata = cfg_r.fall_rate;
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sgsrl_dp.sv -----
// Datapath: classification, shared multiplier, clamp, restoring divider and parameter store.
`default_nettype none

module sgsrl_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sgsrl_pkg::cmd_t             cmd,
  output sgsrl_pkg::sts_t                  sts,
  input  wire sgsrl_pkg::cfg_t             cfg,
  input  wire logic [sgsrl_pkg::VAL_W-1:0] steer_command_abs,
  input  wire logic [sgsrl_pkg::VAL_W-1:0] steer_output_abs,
  input  wire logic                        enabled,
  input  wire logic [sgsrl_pkg::VAL_W-1:0] elapsed_ms,
  output logic      [sgsrl_pkg::VAL_W-1:0] prop_gain,
  output logic      [sgsrl_pkg::VAL_W-1:0] integ_gain,
  output logic      [sgsrl_pkg::VAL_W-1:0] friction_coeff,
  output logic      [sgsrl_pkg::VAL_W-1:0] return_offset
);

  localparam int VW = sgsrl_pkg::VAL_W;
  localparam int WW = sgsrl_pkg::WIDE_W;
  localparam int PW = sgsrl_pkg::MUL_A_W + sgsrl_pkg::MUL_B_W;

  // Pick one 16-bit lane of a packed set, lane 0 in the top bits
  function automatic logic [VW-1:0] lane_of(input logic [sgsrl_pkg::SET_W-1:0] word,
                                            input logic [sgsrl_pkg::LANE_W-1:0] k);
    case (k)
      2'd0:    return word[63:48];
      2'd1:    return word[47:32];
      2'd2:    return word[31:16];
      default: return word[15:0];
    endcase
  endfunction

  // Report classification
  sgsrl_pkg::mode_t mode_r;
  logic [VW-1:0]    ws_r, wc_r, d_r, dt_r;
  logic [VW-1:0]    steer_max;
  sgsrl_pkg::mode_t mode_nxt;

  // Arithmetic registers
  logic        [sgsrl_pkg::SCALE_W-1:0] scale_r;
  logic        [sgsrl_pkg::DTD_W-1:0]   dtd_r;
  logic        [sgsrl_pkg::ACC_W-1:0]   acc_r;
  logic signed [WW-1:0]                 tgt_r, cur_r, up_r, dn_r, tot_r, rem_r, div_r;
  logic        [sgsrl_pkg::Q_W-1:0]     q_r;
  logic [VW-1:0] cur_set_r [sgsrl_pkg::LANES];
  logic [VW-1:0] out_r     [sgsrl_pkg::LANES];

  // Shared multiplier
  logic signed [sgsrl_pkg::MUL_A_W-1:0] mul_a;
  logic signed [sgsrl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]                 prod_full;
  logic signed [WW-1:0]                 prod;
  logic signed [WW-1:0]                 trial;
  logic [VW-1:0]                        straight_k, curve_k, rise_k, fall_k;

  assign straight_k = lane_of(cfg.straight_set, cmd.lane);
  assign curve_k    = lane_of(cfg.curve_set, cmd.lane);
  assign rise_k     = lane_of(cfg.rise_rate, cmd.lane);
  assign fall_k     = lane_of(cfg.fall_rate, cmd.lane);

  // Classify on the larger magnitude
  always_comb begin
    steer_max = (steer_command_abs > steer_output_abs) ? steer_command_abs : steer_output_abs;
    if (!enabled || steer_max >= cfg.high_thr) begin
      mode_nxt = sgsrl_pkg::MODE_CURVE;
    end else if (steer_max <= cfg.low_thr) begin
      mode_nxt = sgsrl_pkg::MODE_STRAIGHT;
    end else begin
      mode_nxt = sgsrl_pkg::MODE_BLEND;
    end
  end

  // Steer multiplier operands by operation
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      sgsrl_pkg::OP_MUL_SCALE: begin
        mul_a = sgsrl_pkg::MUL_A_W'(d_r);
        mul_b = sgsrl_pkg::MUL_B_W'(sgsrl_pkg::MS_PER_S);
      end
      sgsrl_pkg::OP_MUL_DTD: begin
        mul_a = sgsrl_pkg::MUL_A_W'(dt_r);
        mul_b = sgsrl_pkg::MUL_B_W'(d_r);
      end
      sgsrl_pkg::OP_MUL_STR: begin
        mul_a = sgsrl_pkg::MUL_A_W'(straight_k);
        mul_b = sgsrl_pkg::MUL_B_W'(ws_r);
      end
      sgsrl_pkg::OP_MAC_CRV: begin
        mul_a = sgsrl_pkg::MUL_A_W'(curve_k);
        mul_b = sgsrl_pkg::MUL_B_W'(wc_r);
      end
      sgsrl_pkg::OP_MUL_TGT: begin
        mul_a = sgsrl_pkg::MUL_A_W'(acc_r);
        mul_b = sgsrl_pkg::MUL_B_W'(sgsrl_pkg::MS_PER_S);
      end
      sgsrl_pkg::OP_MUL_CUR: begin
        mul_a = sgsrl_pkg::MUL_A_W'(cur_set_r[cmd.lane]);
        mul_b = sgsrl_pkg::MUL_B_W'(scale_r);
      end
      sgsrl_pkg::OP_MUL_UP: begin
        mul_a = sgsrl_pkg::MUL_A_W'(dtd_r);
        mul_b = sgsrl_pkg::MUL_B_W'($signed(rise_k));
      end
      sgsrl_pkg::OP_MUL_DN: begin
        mul_a = sgsrl_pkg::MUL_A_W'(dtd_r);
        mul_b = sgsrl_pkg::MUL_B_W'($signed(fall_k));
      end
      default: ;
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign prod      = $signed(prod_full[WW-1:0]);
  assign trial     = rem_r - div_r;

  // Working registers: products, clamp and divider
  always_ff @(posedge clk) begin
    case (cmd.op)
      sgsrl_pkg::OP_LOAD: begin
        ws_r <= cfg.high_thr - steer_max;
        wc_r <= steer_max - cfg.low_thr;
        d_r  <= cfg.high_thr - cfg.low_thr;
        dt_r <= elapsed_ms;
      end
      sgsrl_pkg::OP_MUL_SCALE: scale_r <= prod[sgsrl_pkg::SCALE_W-1:0];
      sgsrl_pkg::OP_MUL_DTD:   dtd_r   <= prod[sgsrl_pkg::DTD_W-1:0];
      sgsrl_pkg::OP_MUL_STR:   acc_r   <= prod[sgsrl_pkg::ACC_W-1:0];
      sgsrl_pkg::OP_MAC_CRV:   acc_r   <= acc_r + prod[sgsrl_pkg::ACC_W-1:0];
      sgsrl_pkg::OP_MUL_TGT:   tgt_r   <= prod;
      sgsrl_pkg::OP_MUL_CUR:   cur_r   <= prod;
      sgsrl_pkg::OP_MUL_UP:    up_r    <= prod;
      sgsrl_pkg::OP_MUL_DN:    dn_r    <= prod;
      // Shift both step limits onto the current value
      sgsrl_pkg::OP_CLAMP_A: begin
        up_r <= up_r + cur_r;
        dn_r <= dn_r + cur_r;
      end
      // Raise to the fall limit first, then cap at the rise limit
      sgsrl_pkg::OP_CLAMP_B:   tot_r <= (tgt_r < dn_r) ? dn_r : tgt_r;
      sgsrl_pkg::OP_CLAMP_C: begin
        rem_r <= (tot_r > up_r) ? up_r : tot_r;
        div_r <= WW'(scale_r) << (sgsrl_pkg::Q_W - 1);
        q_r   <= '0;
      end
      // One quotient bit per step; a non-positive total yields zero
      sgsrl_pkg::OP_DIV_STEP: begin
        if (!trial[WW-1]) begin
          rem_r <= trial;
        end
        q_r   <= {q_r[sgsrl_pkg::Q_W-2:0], ~trial[WW-1]};
        div_r <= div_r >> 1;
      end
      sgsrl_pkg::OP_PUBLISH: out_r <= cur_set_r;
      default: ;
    endcase
  end

  // Report class and current parameter set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sgsrl_pkg::MODE_CURVE;
      for (int k = 0; k < sgsrl_pkg::LANES; k++) begin
        cur_set_r[k] <= lane_of(sgsrl_pkg::CURVE_RST, sgsrl_pkg::LANE_W'(k));
      end
    end else begin
      case (cmd.op)
        sgsrl_pkg::OP_LOAD: mode_r <= mode_nxt;
        sgsrl_pkg::OP_SET_CURVE: begin
          for (int k = 0; k < sgsrl_pkg::LANES; k++) begin
            cur_set_r[k] <= lane_of(cfg.curve_set, sgsrl_pkg::LANE_W'(k));
          end
        end
        sgsrl_pkg::OP_SET_STRAIGHT: begin
          for (int k = 0; k < sgsrl_pkg::LANES; k++) begin
            cur_set_r[k] <= lane_of(cfg.straight_set, sgsrl_pkg::LANE_W'(k));
          end
        end
        // Saturate the quotient to 16 bits
        sgsrl_pkg::OP_WRITE: begin
          cur_set_r[cmd.lane] <= q_r[sgsrl_pkg::Q_W-1] ? {VW{1'b1}} : q_r[VW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign sts.mode       = mode_r;
  assign prop_gain      = out_r[0];
  assign integ_gain     = out_r[1];
  assign friction_coeff = out_r[2];
  assign return_offset  = out_r[3];

endmodule

`default_nettype wire

// ----- hdl/sgsrl_ctrl.sv -----
// Controller: sequences classification, per-parameter blend, limit, divide and publish.
`default_nettype none

module sgsrl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sgsrl_pkg::cmd_t       cmd,
  input  wire sgsrl_pkg::sts_t  sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_DTD,
    S_STR,
    S_CRV,
    S_TGT,
    S_CUR,
    S_UP,
    S_DN,
    S_CLA,
    S_CLB,
    S_CLC,
    S_DIV,
    S_WRITE,
    S_DONE
  } state_t;

  state_t                           state_r;
  logic [sgsrl_pkg::LANE_W-1:0]     lane_r;
  logic [sgsrl_pkg::BIT_W-1:0]      bit_r;
  logic                             out_valid_r;
  logic                             accept;
  logic                             publish;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign publish   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // Decode the datapath operation for this cycle
  always_comb begin
    cmd.lane = lane_r;
    case (state_r)
      S_IDLE:  cmd.op = accept ? sgsrl_pkg::OP_LOAD : sgsrl_pkg::OP_NOP;
      S_CLASS: begin
        case (sts.mode)
          sgsrl_pkg::MODE_CURVE:    cmd.op = sgsrl_pkg::OP_SET_CURVE;
          sgsrl_pkg::MODE_STRAIGHT: cmd.op = sgsrl_pkg::OP_SET_STRAIGHT;
          default:                  cmd.op = sgsrl_pkg::OP_MUL_SCALE;
        endcase
      end
      S_DTD:   cmd.op = sgsrl_pkg::OP_MUL_DTD;
      S_STR:   cmd.op = sgsrl_pkg::OP_MUL_STR;
      S_CRV:   cmd.op = sgsrl_pkg::OP_MAC_CRV;
      S_TGT:   cmd.op = sgsrl_pkg::OP_MUL_TGT;
      S_CUR:   cmd.op = sgsrl_pkg::OP_MUL_CUR;
      S_UP:    cmd.op = sgsrl_pkg::OP_MUL_UP;
      S_DN:    cmd.op = sgsrl_pkg::OP_MUL_DN;
      S_CLA:   cmd.op = sgsrl_pkg::OP_CLAMP_A;
      S_CLB:   cmd.op = sgsrl_pkg::OP_CLAMP_B;
      S_CLC:   cmd.op = sgsrl_pkg::OP_CLAMP_C;
      S_DIV:   cmd.op = sgsrl_pkg::OP_DIV_STEP;
      S_WRITE: cmd.op = sgsrl_pkg::OP_WRITE;
      S_DONE:  cmd.op = publish ? sgsrl_pkg::OP_PUBLISH : sgsrl_pkg::OP_NOP;
      default: cmd.op = sgsrl_pkg::OP_NOP;
    endcase
  end

  // Advance the sequence; hold the result valid until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          lane_r <= '0;
          if (sts.mode == sgsrl_pkg::MODE_BLEND) begin
            state_r <= S_DTD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DTD:   state_r <= S_STR;
        S_STR:   state_r <= S_CRV;
        S_CRV:   state_r <= S_TGT;
        S_TGT:   state_r <= S_CUR;
        S_CUR:   state_r <= S_UP;
        S_UP:    state_r <= S_DN;
        S_DN:    state_r <= S_CLA;
        S_CLA:   state_r <= S_CLB;
        S_CLB:   state_r <= S_CLC;
        S_CLC: begin
          bit_r   <= sgsrl_pkg::DIV_LAST;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (bit_r == '0) begin
            state_r <= S_WRITE;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        S_WRITE: begin
          if (lane_r == sgsrl_pkg::LANE_W'(sgsrl_pkg::LANES - 1)) begin
            state_r <= S_DONE;
          end else begin
            lane_r  <= lane_r + 1'b1;
            state_r <= S_STR;
          end
        end
        S_DONE: begin
          if (publish) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/steer_gain_scheduler_rate_limited.sv -----
// Top level of the steering gain scheduler with rate limiting.
//
//   channel   kind          transfer when              payload
//   in_ch     valid/ready   valid && ready             magnitudes, enabled, elapsed_ms
//   out_ch    valid/ready   valid && ready             four parameters, 8-byte frame
//   APB       psel/penable  psel, penable, pwrite      six registers at 8 * index
//
// A report that selects the curve or straight set loads that whole set and goes on to
// publish; a blended report takes 2 setup multiplies, then per parameter 6 multiplies
// on the shared multiplier, 3 clamp steps, 17 divider steps and 1 write. The next
// report is taken once the result sits in the output register, so a stalled result
// holds the block only when a second result is ready behind it.
// Reset is synchronous and active low; it restores the registers and the curve set.
`default_nettype none

module steer_gain_scheduler_rate_limited (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sgsrl_in_if.sink                           in_ch,
  sgsrl_out_if.source                        out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sgsrl_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sgsrl_pkg::PDATA_W-1:0] pwdata,
  output logic      [sgsrl_pkg::PDATA_W-1:0] prdata,
  output logic                               pready
);

  sgsrl_pkg::cfg_t cfg;
  sgsrl_pkg::cmd_t cmd;
  sgsrl_pkg::sts_t sts;

  // Configuration registers
  sgsrl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  sgsrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic and parameter store
  sgsrl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg),
    .steer_command_abs (in_ch.steer_command_abs),
    .steer_output_abs  (in_ch.steer_output_abs),
    .enabled           (in_ch.enabled),
    .elapsed_ms        (in_ch.elapsed_ms),
    .prop_gain         (out_ch.prop_gain),
    .integ_gain        (out_ch.integ_gain),
    .friction_coeff    (out_ch.friction_coeff),
    .return_offset     (out_ch.return_offset)
  );

  // Frame bytes: each parameter big-endian, P gain first
  assign out_ch.frame_payload = {out_ch.prop_gain, out_ch.integ_gain,
                                 out_ch.friction_coeff, out_ch.return_offset};

endmodule

`default_nettype wire

// ----- hdl/sgsrl_chk.sv -----
// Port-level checker for the steering gain scheduler, bound to the top level.
`default_nettype none

module sgsrl_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sgsrl_pkg::VAL_W-1:0]   prop_gain,
  input wire logic [sgsrl_pkg::VAL_W-1:0]   integ_gain,
  input wire logic [sgsrl_pkg::VAL_W-1:0]   friction_coeff,
  input wire logic [sgsrl_pkg::VAL_W-1:0]   return_offset,
  input wire logic [sgsrl_pkg::SET_W-1:0]   frame_payload,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [sgsrl_pkg::PADDR_W-1:0] paddr,
  input wire logic [sgsrl_pkg::PDATA_W-1:0] pwdata,
  input wire logic [sgsrl_pkg::PDATA_W-1:0] prdata
);

  // One report at a time: a transfer closes the input until the work is done
  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_payload))
    else $error("result changed or dropped while stalled");

  // Frame bytes agree with the four parameter fields
  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> frame_payload == {prop_gain, integ_gain, friction_coeff, return_offset})
    else $error("frame payload does not match parameter fields");

  // After reset: no result pending, input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A 64-bit register reads back what was last written to it
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && !pwrite && $past(rst_n, 1) && $past(rst_n, 2) &&
    $past(psel && penable && pwrite, 2) && !$past(psel && penable && pwrite, 1) &&
    paddr == $past(paddr, 2) &&
    (paddr[5:3] == sgsrl_pkg::REG_STRAIGHT || paddr[5:3] == sgsrl_pkg::REG_CURVE ||
     paddr[5:3] == sgsrl_pkg::REG_RISE_RATE || paddr[5:3] == sgsrl_pkg::REG_FALL_RATE)
    |-> prdata == $past(pwdata, 2))
    else $error("register read back differs from last write");

endmodule

bind steer_gain_scheduler_rate_limited sgsrl_chk u_sgsrl_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .prop_gain      (out_ch.prop_gain),
  .integ_gain     (out_ch.integ_gain),
  .friction_coeff (out_ch.friction_coeff),
  .return_offset  (out_ch.return_offset),
  .frame_payload  (out_ch.frame_payload),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

`default_nettype wire

// ----- tb/steer_gain_scheduler_rate_limited_tb.sv -----
// Self-checking testbench of the steering gain scheduler with rate limiting.
`timescale 1ns / 100ps

module steer_gain_scheduler_rate_limited_tb;

  // Addresses past the last register; writes there must be ignored
  localparam logic [sgsrl_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [sgsrl_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REPORTS = 130;
  localparam int DRAIN_CYCLES  = 120;

  typedef struct packed {
    logic [sgsrl_pkg::VAL_W-1:0] cmd;
    logic [sgsrl_pkg::VAL_W-1:0] meas;
    logic                        en;
    logic [sgsrl_pkg::VAL_W-1:0] dt;
  } report_t;

  typedef struct packed {
    logic [sgsrl_pkg::VAL_W-1:0] prop;
    logic [sgsrl_pkg::VAL_W-1:0] integ;
    logic [sgsrl_pkg::VAL_W-1:0] fric;
    logic [sgsrl_pkg::VAL_W-1:0] ret;
    logic [sgsrl_pkg::SET_W-1:0] frame;
  } gains_t;

  // Predicts the parameter set per report and checks results in order
  class gain_schedule_board;
    logic [sgsrl_pkg::VAL_W-1:0] low_thr;
    logic [sgsrl_pkg::VAL_W-1:0] high_thr;
    logic [sgsrl_pkg::SET_W-1:0] straight;
    logic [sgsrl_pkg::SET_W-1:0] curve;
    logic [sgsrl_pkg::SET_W-1:0] rise;
    logic [sgsrl_pkg::SET_W-1:0] fall;
    logic [sgsrl_pkg::VAL_W-1:0] held [sgsrl_pkg::LANES];
    gains_t                      due_q [$];
    int                          errors;

    function new();
      low_thr  = sgsrl_pkg::LOW_THR_RST;
      high_thr = sgsrl_pkg::HIGH_THR_RST;
      straight = sgsrl_pkg::STRAIGHT_RST;
      curve    = sgsrl_pkg::CURVE_RST;
      rise     = sgsrl_pkg::RISE_RST;
      fall     = sgsrl_pkg::FALL_RST;
      adopt_set(sgsrl_pkg::CURVE_RST);
      errors   = 0;
    endfunction

    function logic [sgsrl_pkg::VAL_W-1:0] lane_of(logic [sgsrl_pkg::SET_W-1:0] v, int k);
      return v[sgsrl_pkg::SET_W-1-sgsrl_pkg::VAL_W*k -: sgsrl_pkg::VAL_W];
    endfunction

    function longint rate_of(logic [sgsrl_pkg::SET_W-1:0] v, int k);
      logic signed [sgsrl_pkg::VAL_W-1:0] r;
      r = v[sgsrl_pkg::SET_W-1-sgsrl_pkg::VAL_W*k -: sgsrl_pkg::VAL_W];
      return longint'(r);
    endfunction

    function void adopt_set(logic [sgsrl_pkg::SET_W-1:0] s64);
      for (int k = 0; k < sgsrl_pkg::LANES; k++) held[k] = lane_of(s64, k);
    endfunction

    function void write_reg(logic [sgsrl_pkg::REG_IDX_W-1:0] idx,
                            logic [sgsrl_pkg::SET_W-1:0] data);
      case (idx)
        sgsrl_pkg::REG_LOW_THR:   low_thr  = data[sgsrl_pkg::VAL_W-1:0];
        sgsrl_pkg::REG_HIGH_THR:  high_thr = data[sgsrl_pkg::VAL_W-1:0];
        sgsrl_pkg::REG_STRAIGHT:  straight = data;
        sgsrl_pkg::REG_CURVE:     curve    = data;
        sgsrl_pkg::REG_RISE_RATE: rise     = data;
        sgsrl_pkg::REG_FALL_RATE: fall     = data;
        default: ;
      endcase
    endfunction

    // Blend on a common scale of 1 / (1000 * D), clamp the step, truncate, saturate
    function void note_report(report_t r);
      int unsigned s_mag;
      longint d, ws, wc, scale, target, cur, change, up, down, total, q, dt;
      sgsrl_pkg::mode_t mode;
      gains_t due;
      s_mag = (r.cmd > r.meas) ? r.cmd : r.meas;
      dt = longint'(r.dt);
      if (!r.en || s_mag >= high_thr) mode = sgsrl_pkg::MODE_CURVE;
      else if (s_mag <= low_thr) mode = sgsrl_pkg::MODE_STRAIGHT;
      else mode = sgsrl_pkg::MODE_BLEND;
      case (mode)
        sgsrl_pkg::MODE_CURVE:    adopt_set(curve);
        sgsrl_pkg::MODE_STRAIGHT: adopt_set(straight);
        default: begin
          d     = longint'(high_thr) - longint'(low_thr);
          ws    = longint'(high_thr) - longint'(s_mag);
          wc    = longint'(s_mag) - longint'(low_thr);
          scale = longint'(sgsrl_pkg::MS_PER_S) * d;
          for (int k = 0; k < sgsrl_pkg::LANES; k++) begin
            target = (longint'(lane_of(straight, k)) * ws +
                      longint'(lane_of(curve, k)) * wc) * sgsrl_pkg::MS_PER_S;
            cur    = longint'(held[k]) * scale;
            change = target - cur;
            up     = dt * rate_of(rise, k) * d;
            down   = dt * rate_of(fall, k) * d;
            // floor first, ceiling last: crossed limits give the rise limit
            if (change < down) change = down;
            if (change > up) change = up;
            total = cur + change;
            if (total <= 0) begin
              q = 0;
            end else begin
              q = total / scale;
              if (q > 65535) q = 65535;
            end
            held[k] = q[sgsrl_pkg::VAL_W-1:0];
          end
        end
      endcase
      due.prop  = held[0];
      due.integ = held[1];
      due.fric  = held[2];
      due.ret   = held[3];
      due.frame = {held[0], held[1], held[2], held[3]};
      due_q.push_back(due);
    endfunction

    task report(string what, logic [sgsrl_pkg::SET_W-1:0] got,
                logic [sgsrl_pkg::SET_W-1:0] want);
      errors++;
      if (errors <= 40) $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_result(gains_t got);
      gains_t want;
      if (due_q.size() == 0) begin
        report("result with nothing due, frame", got.frame, '0);
        return;
      end
      want = due_q.pop_front();
      if (got.prop !== want.prop)
        report("prop_gain", sgsrl_pkg::SET_W'(got.prop), sgsrl_pkg::SET_W'(want.prop));
      if (got.integ !== want.integ)
        report("integ_gain", sgsrl_pkg::SET_W'(got.integ), sgsrl_pkg::SET_W'(want.integ));
      if (got.fric !== want.fric)
        report("friction_coeff", sgsrl_pkg::SET_W'(got.fric), sgsrl_pkg::SET_W'(want.fric));
      if (got.ret !== want.ret)
        report("return_offset", sgsrl_pkg::SET_W'(got.ret), sgsrl_pkg::SET_W'(want.ret));
      if (got.frame !== want.frame) report("frame_payload", got.frame, want.frame);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sgsrl_pkg::PADDR_W-1:0] paddr;
  logic [sgsrl_pkg::PDATA_W-1:0] pwdata;
  logic [sgsrl_pkg::PDATA_W-1:0] prdata;
  logic pready;
  int gap_pct;
  int stall_pct;
  gain_schedule_board sb;

  sgsrl_in_if  rep_if ();
  sgsrl_out_if res_if ();

  steer_gain_scheduler_rate_limited u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (rep_if),
    .out_ch  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Mostly short pauses, now and then a long one
  function automatic int span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic apb_write(input logic [sgsrl_pkg::REG_IDX_W-1:0] idx,
                           input logic [sgsrl_pkg::SET_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Present one report and hold it until the transfer
  task automatic send_report(input report_t r);
    int gap;
    gap = (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) ? span() : 0;
    if (gap > 0) begin
      rep_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rep_if.valid             <= 1'b1;
    rep_if.steer_command_abs <= r.cmd;
    rep_if.steer_output_abs  <= r.meas;
    rep_if.enabled           <= r.en;
    rep_if.elapsed_ms        <= r.dt;
    do @(posedge clk); while (!rep_if.ready);
    sb.note_report(r);
  endtask

  task automatic send(input int cmd, input int meas, input bit en, input int dt);
    report_t r;
    r.cmd  = sgsrl_pkg::VAL_W'(cmd);
    r.meas = sgsrl_pkg::VAL_W'(meas);
    r.en   = en;
    r.dt   = sgsrl_pkg::VAL_W'(dt);
    send_report(r);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    rep_if.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Magnitudes biased towards the blend region of the current thresholds
  function automatic report_t random_report();
    report_t r;
    int lo, hi, s_mag, other, c;
    lo = int'(sb.low_thr);
    hi = int'(sb.high_thr);
    c  = $urandom_range(0, 99);
    if (lo >= hi || c >= 90) s_mag = $urandom_range(0, 65535);
    else if (c < 60) s_mag = (hi - lo > 1) ? $urandom_range(lo + 1, hi - 1) : lo;
    else if (c < 70) s_mag = ($urandom_range(0, 1) != 0) ? lo : hi;
    else if (c < 80) s_mag = $urandom_range(0, lo);
    else s_mag = $urandom_range(hi, 65535);
    other = $urandom_range(0, s_mag);
    if ($urandom_range(0, 1) != 0) begin
      r.cmd  = sgsrl_pkg::VAL_W'(s_mag);
      r.meas = sgsrl_pkg::VAL_W'(other);
    end else begin
      r.cmd  = sgsrl_pkg::VAL_W'(other);
      r.meas = sgsrl_pkg::VAL_W'(s_mag);
    end
    if ($urandom_range(0, 9) == 0) begin
      r.cmd  = sgsrl_pkg::VAL_W'($urandom);
      r.meas = sgsrl_pkg::VAL_W'($urandom);
    end
    r.en = ($urandom_range(0, 9) != 0);
    c = $urandom_range(0, 99);
    if (c < 60) r.dt = sgsrl_pkg::VAL_W'($urandom_range(0, 100));
    else if (c < 85) r.dt = sgsrl_pkg::VAL_W'($urandom_range(0, 2000));
    else r.dt = sgsrl_pkg::VAL_W'($urandom);
    return r;
  endfunction

  task automatic randomise_config();
    int lo, hi, c;
    logic [sgsrl_pkg::SET_W-1:0] up_v, dn_v;
    c = $urandom_range(0, 9);
    if (c == 0) begin
      lo = $urandom_range(0, 65535);
      hi = $urandom_range(0, 65535);
    end else if (c == 1) begin
      lo = $urandom_range(0, 65535);
      hi = lo;
    end else begin
      lo = $urandom_range(0, 40000);
      hi = lo + $urandom_range(1, (c < 5) ? 2000 : 25535);
    end
    for (int k = 0; k < sgsrl_pkg::LANES; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        up_v[sgsrl_pkg::SET_W-1-sgsrl_pkg::VAL_W*k -: sgsrl_pkg::VAL_W] =
          sgsrl_pkg::VAL_W'($urandom_range(0, 3000));
        dn_v[sgsrl_pkg::SET_W-1-sgsrl_pkg::VAL_W*k -: sgsrl_pkg::VAL_W] =
          sgsrl_pkg::VAL_W'(-int'($urandom_range(0, 3000)));
      end else begin
        up_v[sgsrl_pkg::SET_W-1-sgsrl_pkg::VAL_W*k -: sgsrl_pkg::VAL_W] =
          sgsrl_pkg::VAL_W'($urandom);
        dn_v[sgsrl_pkg::SET_W-1-sgsrl_pkg::VAL_W*k -: sgsrl_pkg::VAL_W] =
          sgsrl_pkg::VAL_W'($urandom);
      end
    end
    apb_write(sgsrl_pkg::REG_LOW_THR, sgsrl_pkg::SET_W'(lo));
    apb_write(sgsrl_pkg::REG_HIGH_THR, sgsrl_pkg::SET_W'(hi));
    apb_write(sgsrl_pkg::REG_STRAIGHT, {$urandom, $urandom});
    apb_write(sgsrl_pkg::REG_CURVE, {$urandom, $urandom});
    apb_write(sgsrl_pkg::REG_RISE_RATE, up_v);
    apb_write(sgsrl_pkg::REG_FALL_RATE, dn_v);
    if ($urandom_range(0, 3) == 0) apb_write(REG_SPARE_A, {$urandom, $urandom});
  endtask

  // Result side: check each transfer, then stall at random
  initial begin
    int hold;
    hold = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.prop_gain, res_if.integ_gain, res_if.friction_coeff,
                         res_if.return_offset, res_if.frame_payload});
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else begin
        res_if.ready <= 1'b1;
        if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) hold = span();
      end
    end
  end

  initial begin
    #12_000_000;
    $display("FAIL steer_gain_scheduler_rate_limited");
    $finish;
  end

  initial begin
    sb        = new();
    gap_pct   = 0;
    stall_pct = 0;
    rst_n                    <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    rep_if.valid             <= 1'b0;
    rep_if.steer_command_abs <= '0;
    rep_if.steer_output_abs  <= '0;
    rep_if.enabled           <= 1'b0;
    rep_if.elapsed_ms        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: both thresholds hit exactly, blend with and without limiting
    send(0, 0, 1'b1, 0);
    send(819, 0, 1'b1, 10);
    send(0, 2048, 1'b1, 5);
    send(1434, 100, 1'b1, 1);
    send(100, 1434, 1'b1, 100);
    send(1434, 1434, 1'b0, 100);
    send(65535, 65535, 1'b1, 65535);
    send(1000, 1900, 1'b1, 0);
    send(1900, 1000, 1'b1, 65535);
    settle();

    // Extremes of every register
    apb_write(sgsrl_pkg::REG_LOW_THR, 64'd0);
    apb_write(sgsrl_pkg::REG_HIGH_THR, 64'd65535);
    apb_write(sgsrl_pkg::REG_STRAIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(sgsrl_pkg::REG_CURVE, 64'h0);
    apb_write(sgsrl_pkg::REG_RISE_RATE, 64'h7FFF_7FFF_7FFF_7FFF);
    apb_write(sgsrl_pkg::REG_FALL_RATE, 64'h8000_8000_8000_8000);
    send(0, 0, 1'b1, 3);
    send(1, 0, 1'b1, 65535);
    send(32768, 7, 1'b1, 1);
    send(0, 65534, 1'b1, 65535);
    send(65535, 0, 1'b1, 9);
    send(40000, 0, 1'b0, 9);
    settle();

    // Crossed thresholds leave no blend region; spare addresses are ignored
    apb_write(sgsrl_pkg::REG_LOW_THR, 64'd65535);
    apb_write(sgsrl_pkg::REG_HIGH_THR, 64'd0);
    apb_write(REG_SPARE_A, 64'hDEAD_BEEF_0123_4567);
    apb_write(REG_SPARE_B, 64'h0000_FFFF_0000_FFFF);
    send(0, 0, 1'b1, 50);
    settle();
    apb_write(sgsrl_pkg::REG_LOW_THR, 64'd3000);
    apb_write(sgsrl_pkg::REG_HIGH_THR, 64'd1000);
    send(2000, 0, 1'b1, 50);
    send(0, 500, 1'b1, 50);
    send(1000, 999, 1'b1, 50);
    settle();

    // Crossed rate limits: the rise limit wins, saturating high and at zero
    apb_write(sgsrl_pkg::REG_LOW_THR, 64'd0);
    apb_write(sgsrl_pkg::REG_HIGH_THR, 64'd65535);
    apb_write(sgsrl_pkg::REG_STRAIGHT, 64'h1234_0ABC_FFFF_0001);
    apb_write(sgsrl_pkg::REG_CURVE, 64'h0001_7777_0000_FFFF);
    apb_write(sgsrl_pkg::REG_RISE_RATE, 64'h7000_8000_7000_8000);
    apb_write(sgsrl_pkg::REG_FALL_RATE, 64'h7FFF_7FFF_7FFF_7FFF);
    send(30000, 0, 1'b1, 65535);
    send(0, 30000, 1'b1, 0);
    send(20000, 20000, 1'b1, 1);
    settle();

    // Random settings per phase, some phases without any idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      randomise_config();
      if (ph % 3 == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 50);
        stall_pct = $urandom_range(10, 50);
      end
      repeat (PHASE_REPORTS) send_report(random_report());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("PASS steer_gain_scheduler_rate_limited");
    end else begin
      $display("FAIL steer_gain_scheduler_rate_limited");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sgsrl_pkg.sv
hdl/sgsrl_if.sv
hdl/sgsrl_regs.sv
hdl/sgsrl_dp.sv
hdl/sgsrl_ctrl.sv
hdl/steer_gain_scheduler_rate_limited.sv
hdl/sgsrl_chk.sv
tb/steer_gain_scheduler_rate_limited_tb.sv
